// ===== rtl/srd_pkg.sv =====
// Shared types and constants for the serialized reply deframer.
`timescale 1ns / 1ps

package srd_pkg;

  // Bulk length limit and the widths that follow from it.
  localparam int MAX_BULK_LEN = 1048576;
  localparam int LEN_W        = $clog2(MAX_BULK_LEN + 1);
  localparam int MUL_W        = LEN_W + 4;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_BULK_LEN);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  // Framing characters.
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Reply kinds.
  localparam logic [2:0] KIND_SIMPLE = 3'd0;
  localparam logic [2:0] KIND_ERROR  = 3'd1;
  localparam logic [2:0] KIND_INT    = 3'd2;
  localparam logic [2:0] KIND_BULK   = 3'd3;
  localparam logic [2:0] KIND_NIL    = 3'd4;
  localparam logic [2:0] KIND_FAULT  = 3'd5;

  // Fault codes.
  localparam logic [2:0] FLT_NONE       = 3'd0;
  localparam logic [2:0] FLT_NO_RESP    = 3'd1;
  localparam logic [2:0] FLT_UNKNOWN    = 3'd2;
  localparam logic [2:0] FLT_INCOMPLETE = 3'd3;
  localparam logic [2:0] FLT_BAD_LEN    = 3'd4;
  localparam logic [2:0] FLT_TOO_LONG   = 3'd5;

  // Parser phase, one-hot.
  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_LINE    = 8'b0000_0010,
    PH_LINE_LF = 8'b0000_0100,
    PH_LEN     = 8'b0000_1000,
    PH_LEN_LF  = 8'b0001_0000,
    PH_PAY     = 8'b0010_0000,
    PH_TR1     = 8'b0100_0000,
    PH_TR2     = 8'b1000_0000
  } phase_t;

  // Length line parse flags.
  typedef struct packed {
    logic stop;
    logic sat;
    logic dig;
    logic neg;
  } len_flags_t;

  // One result item as produced by the parser step.
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] reply_kind;
    logic [2:0] fault_code;
    logic       reply_end;
  } result_t;

endpackage

// ===== rtl/srd_parser.sv =====
// Parser state and the per-byte step logic of the reply deframer.
`timescale 1ns / 1ps

module srd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  input  logic            link_closed,
  output srd_pkg::result_t result
);
  import srd_pkg::*;

  phase_t           phase, phase_next;
  logic [1:0]       current_kind, current_kind_next;
  logic [LEN_W-1:0] length_value, length_value_next;
  len_flags_t       length_flags, length_flags_next;
  logic [LEN_W-1:0] bytes_remaining, bytes_remaining_next;

  logic [MUL_W-1:0] len_times_ten;
  logic [MUL_W-1:0] len_acc;
  logic             is_digit;
  logic             sat_bulk;

  // Decimal accumulate: value * 10 + digit, by shift and add.
  assign is_digit      = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign len_times_ten = {length_value, 3'b000} + {2'b00, length_value, 1'b0};
  assign len_acc       = len_times_ten + MUL_W'(rx_byte - CH_ZERO);
  assign sat_bulk      = length_flags.sat;

  // Next state and result for the byte in hand.
  always_comb begin
    phase_next           = phase;
    current_kind_next    = current_kind;
    length_value_next    = length_value;
    length_flags_next    = length_flags;
    bytes_remaining_next = bytes_remaining;
    result               = '0;

    unique case (phase)
      PH_LINE: begin
        if (link_closed) begin
          phase_next        = PH_IDLE;
          result.valid      = 1'b1;
          result.reply_kind = {1'b0, current_kind};
          result.reply_end  = 1'b1;
        end else if (rx_byte == CH_CR) begin
          phase_next = PH_LINE_LF;
        end else begin
          result.valid      = 1'b1;
          result.out_byte   = rx_byte;
          result.byte_valid = 1'b1;
          result.reply_kind = {1'b0, current_kind};
        end
      end

      PH_LINE_LF: begin
        phase_next        = PH_IDLE;
        result.valid      = 1'b1;
        result.reply_kind = {1'b0, current_kind};
        result.reply_end  = 1'b1;
      end

      PH_LEN: begin
        if (link_closed) begin
          phase_next        = PH_IDLE;
          result.valid      = 1'b1;
          result.reply_kind = KIND_FAULT;
          result.fault_code = FLT_INCOMPLETE;
          result.reply_end  = 1'b1;
        end else if (rx_byte == CH_CR) begin
          phase_next = PH_LEN_LF;
        end else if (!length_flags.stop) begin
          priority if (rx_byte == CH_MINUS && length_flags == '0) begin
            length_flags_next     = '0;
            length_flags_next.neg = 1'b1;
          end else if (is_digit) begin
            length_flags_next.dig = 1'b1;
            if (len_acc > MUL_W'(LEN_MAX)) begin
              length_value_next     = LEN_MAX;
              length_flags_next.sat = 1'b1;
            end else begin
              length_value_next = len_acc[LEN_W-1:0];
            end
          end else begin
            length_flags_next.stop = 1'b1;
          end
        end
      end

      PH_LEN_LF: begin
        if (link_closed) begin
          phase_next        = PH_IDLE;
          result.valid      = 1'b1;
          result.reply_kind = KIND_FAULT;
          result.fault_code = FLT_INCOMPLETE;
          result.reply_end  = 1'b1;
        end else if (!length_flags.dig) begin
          phase_next        = PH_IDLE;
          result.valid      = 1'b1;
          result.reply_kind = KIND_FAULT;
          result.fault_code = FLT_BAD_LEN;
          result.reply_end  = 1'b1;
        end else if (length_flags.neg &&
                     (length_value != '0 || length_flags.sat)) begin
          phase_next       = PH_IDLE;
          result.valid     = 1'b1;
          result.reply_end = 1'b1;
          if (length_value == LEN_ONE && !length_flags.sat) begin
            result.reply_kind = KIND_NIL;
          end else begin
            result.reply_kind = KIND_FAULT;
            result.fault_code = FLT_BAD_LEN;
          end
        end else begin
          bytes_remaining_next = length_value;
          phase_next           = (length_value == '0) ? PH_TR1 : PH_PAY;
        end
      end

      PH_PAY: begin
        if (link_closed) begin
          phase_next        = PH_IDLE;
          result.valid      = 1'b1;
          result.reply_kind = KIND_FAULT;
          result.fault_code = FLT_INCOMPLETE;
          result.reply_end  = 1'b1;
        end else begin
          if (bytes_remaining <= LEN_ONE) begin
            bytes_remaining_next = '0;
            phase_next           = PH_TR1;
          end else begin
            bytes_remaining_next = bytes_remaining - LEN_ONE;
          end
          result.valid      = 1'b1;
          result.out_byte   = rx_byte;
          result.byte_valid = 1'b1;
          result.reply_kind = KIND_BULK;
        end
      end

      PH_TR1, PH_TR2: begin
        if (phase == PH_TR1 && !link_closed) begin
          phase_next = PH_TR2;
        end else begin
          phase_next       = PH_IDLE;
          result.valid     = 1'b1;
          result.reply_end = 1'b1;
          if (sat_bulk) begin
            result.reply_kind = KIND_FAULT;
            result.fault_code = FLT_TOO_LONG;
          end else begin
            result.reply_kind = KIND_BULK;
          end
        end
      end

      default: begin
        // Idle: wait for a prefix byte.
        phase_next = PH_IDLE;
        if (link_closed) begin
          result.valid      = 1'b1;
          result.reply_kind = KIND_FAULT;
          result.fault_code = FLT_NO_RESP;
          result.reply_end  = 1'b1;
        end else begin
          length_value_next    = '0;
          length_flags_next    = '0;
          bytes_remaining_next = '0;
          priority if (rx_byte == CH_PLUS) begin
            current_kind_next = KIND_SIMPLE[1:0];
            phase_next        = PH_LINE;
          end else if (rx_byte == CH_MINUS) begin
            current_kind_next = KIND_ERROR[1:0];
            phase_next        = PH_LINE;
          end else if (rx_byte == CH_COLON) begin
            current_kind_next = KIND_INT[1:0];
            phase_next        = PH_LINE;
          end else if (rx_byte == CH_DOLLAR) begin
            current_kind_next = KIND_BULK[1:0];
            phase_next        = PH_LEN;
          end else begin
            result.valid      = 1'b1;
            result.reply_kind = KIND_FAULT;
            result.fault_code = FLT_UNKNOWN;
            result.reply_end  = 1'b1;
          end
        end
      end
    endcase
  end

  // State registers advance once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      current_kind    <= '0;
      length_value    <= '0;
      length_flags    <= '0;
      bytes_remaining <= '0;
    end else if (step) begin
      phase           <= phase_next;
      current_kind    <= current_kind_next;
      length_value    <= length_value_next;
      length_flags    <= length_flags_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

// ===== rtl/serialized_reply_deframer_core.sv =====
// Top level of the serialized reply deframer: input and result registers.
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// input    in_valid / in_ready    rx_byte, link_closed
// result   out_valid / out_ready  out_byte, byte_valid, reply_kind,
//                                 fault_code, reply_end
//
// A byte is taken into the input register and processed by the parser when
// the result register is empty or being read; its result, if any, lands in
// the result register. One byte per cycle is sustained while out_ready is
// high. The input stage keeps taking bytes while the result register is
// full until the input register itself holds a byte that waits for it.
// Synchronous reset returns the parser to idle and empties both registers.

module serialized_reply_deframer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       link_closed,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [2:0] reply_kind,
  output logic [2:0] fault_code,
  output logic       reply_end
);
  import srd_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_closed;
  logic       advance;
  logic       out_full;
  result_t    step_result;
  result_t    out_reg;

  // The held byte moves on when the result register can take its result.
  assign advance  = in_full && (!out_full || out_ready);
  assign in_ready = !in_full || advance;

  srd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .rx_byte     (in_byte),
    .link_closed (in_closed),
    .result      (step_result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte   <= rx_byte;
      in_closed <= link_closed;
    end
  end

  // Result register: loaded on a processed byte, emptied on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= step_result.valid;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_result.valid) begin
      out_reg <= step_result;
    end
  end

  assign out_valid  = out_full;
  assign out_byte   = out_reg.out_byte;
  assign byte_valid = out_reg.byte_valid;
  assign reply_kind = out_reg.reply_kind;
  assign fault_code = out_reg.fault_code;
  assign reply_end  = out_reg.reply_end;

endmodule

// ===== test/tb_serialized_reply_deframer_core.sv =====
// Self-checking testbench for the serialized reply deframer core.
`timescale 1ns / 1ps

module tb_serialized_reply_deframer_core;
  import srd_pkg::*;

  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // One reply transfer, in the order of the result ports.
  typedef struct packed {
    logic [7:0] data;
    logic       data_ok;
    logic [2:0] kind;
    logic [2:0] fault;
    logic       last;
  } reply_t;

  // One input byte; pinned rows carry a hand-written expectation.
  typedef struct packed {
    logic [7:0] rx;
    logic       closed;
    logic       pinned;
    logic       pin_has;
    reply_t     pin_reply;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       link_closed = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] reply_kind;
  logic [2:0] fault_code;
  logic       reply_end;

  // Deframer state as predicted from the accepted bytes.
  phase_t           p_phase;
  logic [2:0]       p_kind;
  logic [LEN_W-1:0] p_len;
  len_flags_t       p_flags;
  logic [LEN_W-1:0] p_left;

  reply_t      pending_replies[$];
  stim_row_t   directed_rows[$];
  stim_row_t   frame_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned random_items = 0;
  logic        hold_request = 1'b0;
  logic        hold_done;
  int unsigned hold_count;
  logic [15:0] stall_mask;
  logic [3:0]  stall_pos;

  serialized_reply_deframer_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .link_closed(link_closed),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .reply_kind (reply_kind),
    .fault_code (fault_code),
    .reply_end  (reply_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic reply_t rep(logic [7:0] d, logic ok, logic [2:0] k, logic [2:0] f,
                                 logic e);
    return {d, ok, k, f, e};
  endfunction

  function automatic stim_row_t chk(logic [7:0] b, logic c);
    return {b, c, 1'b0, 1'b0, reply_t'('0)};
  endfunction

  function automatic stim_row_t pin(logic [7:0] b, logic c, logic has, reply_t r);
    return {b, c, 1'b1, has, r};
  endfunction

  function automatic string show(reply_t r);
    return $sformatf("byte %02h ok %0d kind %0d fault %0d end %0d",
                     r.data, r.data_ok, r.kind, r.fault, r.last);
  endfunction

  // Append one row to the frame under construction.
  function automatic void frame_add(stim_row_t row);
    frame_q = {frame_q, row};
  endfunction

  // Append one row to the directed table.
  function automatic void directed_add(stim_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  // Advance the predicted parser by one byte or link-closed event.
  task automatic deframe_step(input logic [7:0] b, input logic c, output logic has,
                              output reply_t r);
    logic [MUL_W-1:0] wide;
    logic             fin;
    logic [2:0]       fk;
    logic [2:0]       ff;
    has = 1'b0;
    r   = '0;
    fin = 1'b0;
    fk  = KIND_FAULT;
    ff  = FLT_NONE;
    case (p_phase)
      PH_LINE: begin
        if (c) begin
          fin = 1'b1;
          fk  = p_kind;
        end else if (b == CH_CR) begin
          p_phase = PH_LINE_LF;
        end else begin
          has = 1'b1;
          r   = rep(b, 1'b1, p_kind, FLT_NONE, 1'b0);
        end
      end
      PH_LINE_LF: begin
        fin = 1'b1;
        fk  = p_kind;
      end
      PH_LEN: begin
        if (c) begin
          fin = 1'b1;
          ff  = FLT_INCOMPLETE;
        end else if (b == CH_CR) begin
          p_phase = PH_LEN_LF;
        end else if (!p_flags.stop) begin
          if (b == CH_MINUS && p_flags == 4'b0000) begin
            p_flags.neg = 1'b1;
          end else if (b >= CH_ZERO && b <= CH_NINE) begin
            wide = MUL_W'(MUL_W'(p_len) * 10 + MUL_W'(b - CH_ZERO));
            p_flags.dig = 1'b1;
            if (wide > MUL_W'(MAX_BULK_LEN)) begin
              wide = MUL_W'(MAX_BULK_LEN);
              p_flags.sat = 1'b1;
            end
            p_len = LEN_W'(wide);
          end else begin
            p_flags.stop = 1'b1;
          end
        end
      end
      PH_LEN_LF: begin
        if (c) begin
          fin = 1'b1;
          ff  = FLT_INCOMPLETE;
        end else if (!p_flags.dig) begin
          fin = 1'b1;
          ff  = FLT_BAD_LEN;
        end else if (p_flags.neg && (p_len != '0 || p_flags.sat)) begin
          fin = 1'b1;
          if (p_len == LEN_ONE && !p_flags.sat) begin
            fk = KIND_NIL;
          end else begin
            ff = FLT_BAD_LEN;
          end
        end else begin
          p_left = p_len;
          if (p_len == '0) begin
            p_phase = PH_TR1;
          end else begin
            p_phase = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        if (c) begin
          fin = 1'b1;
          ff  = FLT_INCOMPLETE;
        end else begin
          if (p_left <= LEN_ONE) begin
            p_left  = '0;
            p_phase = PH_TR1;
          end else begin
            p_left = p_left - 1'b1;
          end
          has = 1'b1;
          r   = rep(b, 1'b1, KIND_BULK, FLT_NONE, 1'b0);
        end
      end
      PH_TR1, PH_TR2: begin
        if (c || p_phase == PH_TR2) begin
          fin = 1'b1;
          fk  = p_flags.sat ? KIND_FAULT : KIND_BULK;
          ff  = p_flags.sat ? FLT_TOO_LONG : FLT_NONE;
        end else begin
          p_phase = PH_TR2;
        end
      end
      default: begin
        // Idle, and any phase code that should never occur.
        p_phase = PH_IDLE;
        if (c) begin
          fin = 1'b1;
          ff  = FLT_NO_RESP;
        end else begin
          p_len   = '0;
          p_flags = '0;
          p_left  = '0;
          if (b == CH_PLUS || b == CH_MINUS || b == CH_COLON) begin
            p_kind  = (b == CH_PLUS) ? KIND_SIMPLE : (b == CH_MINUS) ? KIND_ERROR : KIND_INT;
            p_phase = PH_LINE;
          end else if (b == CH_DOLLAR) begin
            p_kind  = KIND_BULK;
            p_phase = PH_LEN;
          end else begin
            fin = 1'b1;
            ff  = FLT_UNKNOWN;
          end
        end
      end
    endcase
    if (fin) begin
      has     = 1'b1;
      r       = rep(8'h00, 1'b0, fk, ff, 1'b1);
      p_phase = PH_IDLE;
    end
  endtask

  // Offer one byte, wait for its transfer, then record what it should produce.
  task automatic offer(input stim_row_t row);
    int unsigned gap;
    logic        has;
    reply_t      r;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 48);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    rx_byte     <= row.rx;
    link_closed <= row.closed;
    do @(posedge clk); while (!in_ready);
    deframe_step(row.rx, row.closed, has, r);
    if (row.pinned) begin
      has = row.pin_has;
      r   = row.pin_reply;
    end
    if (has) pending_replies = {pending_replies, r};
  endtask

  task automatic push_number(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) frame_add(chk(s[i], 1'b0));
  endtask

  // One random frame: mostly well-formed replies with random content,
  // some malformed length lines, some noise, and some cut short by a close.
  task automatic build_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    logic        body;
    logic        over;
    logic [7:0]  b;
    frame_q.delete();
    body = 1'b1;
    over = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      case ($urandom_range(0, 2))
        0: frame_add(chk(CH_PLUS, 1'b0));
        1: frame_add(chk(CH_MINUS, 1'b0));
        default: frame_add(chk(CH_COLON, 1'b0));
      endcase
      repeat ($urandom_range(0, 10)) begin
        b = 8'($urandom);
        if (b == CH_CR) b = 8'h61;
        frame_add(chk(b, 1'b0));
      end
      frame_add(chk(CH_CR, 1'b0));
      b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : CH_LF;
      frame_add(chk(b, 1'b0));
    end else if (pick < 85) begin
      frame_add(chk(CH_DOLLAR, 1'b0));
      len = $urandom_range(0, 12);
      case ($urandom_range(0, 11))
        0: begin
          frame_add(chk(CH_MINUS, 1'b0));
          push_number(1);
          body = 1'b0;
        end
        1: begin
          frame_add(chk(CH_MINUS, 1'b0));
          push_number($urandom_range(2, 500));
          body = 1'b0;
        end
        2: begin
          // Length lines that never reach a digit.
          case ($urandom_range(0, 3))
            0: ;
            1: frame_add(chk(CH_PLUS, 1'b0));
            2: frame_add(chk(8'h20, 1'b0));
            default: frame_add(chk(CH_MINUS, 1'b0));
          endcase
          if (frame_q.size() > 1) begin
            if (frame_q[1].rx == CH_MINUS) frame_add(chk(CH_MINUS, 1'b0));
            push_number(len);
          end
          body = 1'b0;
        end
        3: begin
          frame_add(chk(CH_MINUS, 1'b0));
          push_number(0);
          len = 0;
        end
        4: begin
          push_number($urandom_range(99999999, MAX_BULK_LEN + 1));
          len  = $urandom_range(0, 6);
          over = 1'b1;
        end
        5: begin
          // Digits, then a stop byte and more bytes that are ignored.
          push_number(len);
          case ($urandom_range(0, 3))
            0: frame_add(chk(8'h20, 1'b0));
            1: frame_add(chk(CH_MINUS, 1'b0));
            2: frame_add(chk(8'hFF, 1'b0));
            default: frame_add(chk(8'h78, 1'b0));
          endcase
          push_number($urandom_range(0, 99));
        end
        6: begin
          frame_add(chk(CH_ZERO, 1'b0));
          push_number(len);
        end
        default: push_number(len);
      endcase
      frame_add(chk(CH_CR, 1'b0));
      frame_add(chk(CH_LF, 1'b0));
      if (body) begin
        repeat (len) frame_add(chk(8'($urandom), 1'b0));
        if (over) begin
          frame_add(chk(8'($urandom), 1'b1));
        end else if ($urandom_range(0, 3) == 0) begin
          frame_add(chk(8'($urandom), 1'b0));
          frame_add(chk(8'($urandom), 1'b0));
        end else begin
          frame_add(chk(CH_CR, 1'b0));
          frame_add(chk(CH_LF, 1'b0));
        end
      end
    end else if (pick < 93) begin
      frame_add(chk(8'($urandom), 1'b0));
    end else begin
      frame_add(chk(8'($urandom), 1'b1));
    end
    // Now and then the link closes partway through the frame.
    if ($urandom_range(0, 9) == 0 && frame_q.size() > 1) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
      frame_add(chk(8'($urandom), 1'b1));
    end
  endtask

  // Result side: check every transfer and pick the next ready value.
  always @(posedge clk) begin : result_side
    reply_t got;
    reply_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_mask <= '1;
      stall_pos  <= '0;
      hold_count <= 0;
      hold_done  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = rep(out_byte, byte_valid, reply_kind, fault_code, reply_end);
        if (pending_replies.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected reply: %s", show(got));
          mismatch_count++;
        end else begin
          want = pending_replies.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display("reply mismatch: expected %s, got %s", show(want), show(got));
            mismatch_count++;
          end
        end
      end
      // A single long hold-off lets the core fill up and stall its input.
      if (hold_request && !hold_done) begin
        out_ready  <= 1'b0;
        hold_count <= hold_count + 1;
        if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else begin
        out_ready <= stall_mask[stall_pos];
      end
      stall_pos <= stall_pos + 1'b1;
      if (stall_pos == '1) begin
        case ($urandom_range(0, 3))
          0: stall_mask <= '1;
          1: stall_mask <= 16'($urandom);
          2: stall_mask <= 16'($urandom | $urandom);
          default: stall_mask <= 16'($urandom & $urandom);
        endcase
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_serialized_reply_deframer_core: FAIL");
      $finish;
    end
  end

  initial begin
    p_phase = PH_IDLE;
    p_kind  = KIND_SIMPLE;
    p_len   = '0;
    p_flags = '0;
    p_left  = '0;

    // Directed rows: a close and unknown prefixes at idle, each line kind,
    // nil, missing digits, minus zero, a close in the trailer, another
    // negative, and a close in the length line.
    directed_add(pin(8'hFF, 1'b1, 1'b1, rep(8'h00, 1'b0, KIND_FAULT, FLT_NO_RESP, 1'b1)));
    directed_add(pin(8'h00, 1'b0, 1'b1, rep(8'h00, 1'b0, KIND_FAULT, FLT_UNKNOWN, 1'b1)));
    directed_add(pin(8'hFF, 1'b0, 1'b1, rep(8'h00, 1'b0, KIND_FAULT, FLT_UNKNOWN, 1'b1)));
    directed_add(pin(CH_PLUS, 1'b0, 1'b0, '0));
    directed_add(pin(8'hFF, 1'b0, 1'b1, rep(8'hFF, 1'b1, KIND_SIMPLE, FLT_NONE, 1'b0)));
    directed_add(pin(8'h00, 1'b0, 1'b1, rep(8'h00, 1'b1, KIND_SIMPLE, FLT_NONE, 1'b0)));
    directed_add(pin(CH_CR, 1'b0, 1'b0, '0));
    directed_add(pin(8'hFF, 1'b0, 1'b1, rep(8'h00, 1'b0, KIND_SIMPLE, FLT_NONE, 1'b1)));
    directed_add(chk(CH_MINUS, 1'b0));
    directed_add(chk(8'h45, 1'b0));
    directed_add(chk(8'h00, 1'b1));
    directed_add(chk(CH_COLON, 1'b0));
    directed_add(chk(CH_CR, 1'b0));
    directed_add(chk(8'h00, 1'b1));
    directed_add(chk(CH_DOLLAR, 1'b0));
    directed_add(chk(CH_MINUS, 1'b0));
    directed_add(chk(CH_ZERO + 8'd1, 1'b0));
    directed_add(chk(CH_CR, 1'b0));
    directed_add(pin(CH_LF, 1'b0, 1'b1, rep(8'h00, 1'b0, KIND_NIL, FLT_NONE, 1'b1)));
    directed_add(chk(CH_DOLLAR, 1'b0));
    directed_add(chk(CH_PLUS, 1'b0));
    directed_add(chk(CH_CR, 1'b0));
    directed_add(pin(CH_LF, 1'b0, 1'b1, rep(8'h00, 1'b0, KIND_FAULT, FLT_BAD_LEN, 1'b1)));
    directed_add(chk(CH_DOLLAR, 1'b0));
    directed_add(chk(CH_MINUS, 1'b0));
    directed_add(chk(CH_ZERO, 1'b0));
    directed_add(chk(CH_CR, 1'b0));
    directed_add(chk(CH_LF, 1'b0));
    directed_add(chk(8'hFF, 1'b1));
    directed_add(chk(CH_DOLLAR, 1'b0));
    directed_add(chk(CH_MINUS, 1'b0));
    directed_add(chk(CH_NINE, 1'b0));
    directed_add(chk(CH_CR, 1'b0));
    directed_add(pin(CH_LF, 1'b0, 1'b1, rep(8'h00, 1'b0, KIND_FAULT, FLT_BAD_LEN, 1'b1)));
    directed_add(chk(CH_DOLLAR, 1'b0));
    directed_add(pin(8'h00, 1'b1, 1'b1, rep(8'h00, 1'b0, KIND_FAULT, FLT_INCOMPLETE, 1'b1)));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) offer(directed_rows[i]);

    // Random frames with idling on both sides.
    while (random_items < RANDOM_ITEMS) begin
      build_frame();
      foreach (frame_q[i]) begin
        offer(frame_q[i]);
        random_items++;
        if (random_items == RANDOM_ITEMS / 2) hold_request = 1'b1;
      end
    end
    in_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("tb_serialized_reply_deframer_core: PASS");
    end else begin
      $display("tb_serialized_reply_deframer_core: FAIL");
    end
    $finish;
  end

endmodule
